// ----- hw/rtl/tpaf_pkg.sv -----
// Shared types and constants for the triac phase-angle firing block.
package tpaf_pkg;

	// Field widths of the stream words and configuration registers
	localparam int CMD_W      = 2;
	localparam int DUTY_W     = 7;
	localparam int TICK_W     = 10;
	localparam int US_W       = 16;
	localparam int CFG_IDX_W  = 3;

	// Percent scale of the duty
	localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(100);

	// Division by 100 as a multiply by ceil(2^30 / 100) and a shift by 30,
	// exact for every dividend below 2^23
	localparam int                RECIP_SHIFT = 30;
	localparam int                RECIP_W     = 31;
	localparam logic [23:0]       RECIP_M     = 24'd10737419;

	// Command codes carried in the input tuser
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ZC   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RAMP = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;  // unused code, changes nothing

	// Zero-cross tracking states
	localparam logic [1:0] ZC_NONE    = 2'd0;
	localparam logic [1:0] ZC_PENDING = 2'd1;
	localparam logic [1:0] ZC_SEEN    = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZC_ADJUST   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_LOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_HIGH   = 3'd5;

	// Configuration register file
	typedef struct packed {
		logic [TICK_W-1:0] tick_step_us;
		logic [US_W-1:0]   pulse_width_us;
		logic [US_W-1:0]   zc_delay_adjust_us;
		logic [US_W-1:0]   half_period_us;
		logic [DUTY_W-1:0] duty_low_limit;
		logic [DUTY_W-1:0] duty_high_limit;
	} cfg_t;

endpackage

// ----- hw/rtl/triac_phase_angle_firing.sv -----
// Top level of the triac phase-angle firing block.
// A word is held in the input register, its result in the result register.
// One word per cycle unless the output stalls; state updates in one pass.
// Reset: arst_n clears state and gate, loads register defaults at once.
// Input register and result register decouple the two stream sides.
module triac_phase_angle_firing #(
	parameter int COUNT_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // enable, target_duty
	input  logic [tpaf_pkg::CMD_W-1:0]        s_axis_tuser,  // cmd
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [7:0]                        m_axis_tdata,  // gate, duty_now
	input  logic                              cfg_we,
	input  logic [tpaf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tpaf_pkg::US_W-1:0]         cfg_wdata
);
	import tpaf_pkg::*;

	cfg_t cfg_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_step_us       <= TICK_W'(100);
			cfg_q.pulse_width_us     <= US_W'(100);
			cfg_q.zc_delay_adjust_us <= US_W'(1500);
			cfg_q.half_period_us     <= US_W'(10000);
			cfg_q.duty_low_limit     <= DUTY_W'(5);
			cfg_q.duty_high_limit    <= DUTY_W'(95);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICK_STEP:   cfg_q.tick_step_us       <= cfg_wdata[TICK_W-1:0];
				REG_PULSE_WIDTH: cfg_q.pulse_width_us     <= cfg_wdata;
				REG_ZC_ADJUST:   cfg_q.zc_delay_adjust_us <= cfg_wdata;
				REG_HALF_PERIOD: cfg_q.half_period_us     <= cfg_wdata;
				REG_DUTY_LOW:    cfg_q.duty_low_limit     <= cfg_wdata[DUTY_W-1:0];
				REG_DUTY_HIGH:   cfg_q.duty_high_limit    <= cfg_wdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	logic              in_valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic              enable_s1;
	logic [DUTY_W-1:0] target_s1;
	logic              advance;
	logic              out_valid_q;
	logic              gate_nxt;
	logic [DUTY_W-1:0] duty_nxt;
	logic              gate_q;
	logic [DUTY_W-1:0] duty_q;

	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_valid_s1 <= 1'b0;
		else if (s_axis_tready)
			in_valid_s1 <= s_axis_tvalid;
	end

	// Hold the input word until it is processed
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1    <= s_axis_tuser;
			enable_s1 <= s_axis_tdata[0];
			target_s1 <= s_axis_tdata[DUTY_W:1];
		end
	end

	tpaf_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.cmd         (cmd_s1),
		.enable      (enable_s1),
		.target_duty (target_s1),
		.cfg         (cfg_q),
		.gate_nxt    (gate_nxt),
		.duty_nxt    (duty_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gate_q <= gate_nxt;
			duty_q <= duty_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {duty_q, gate_q};

endmodule

// ----- hw/rtl/tpaf_core.sv -----
// Firing state: duty ramp, timing recompute, half-cycle counters and gate level.
module tpaf_core #(
	parameter int COUNT_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [tpaf_pkg::CMD_W-1:0]   cmd,
	input  logic                         enable,
	input  logic [tpaf_pkg::DUTY_W-1:0]  target_duty,
	input  tpaf_pkg::cfg_t               cfg,
	output logic                         gate_nxt,
	output logic [tpaf_pkg::DUTY_W-1:0]  duty_nxt
);
	import tpaf_pkg::*;

	localparam int CW      = COUNT_BITS + 1;
	localparam int TIME_W  = US_W + 1;
	localparam int TBL_N   = 2 ** DUTY_W;
	localparam int PROD_W  = US_W + RECIP_W;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [DUTY_W-1:0]     ramp_duty_q;
	logic [COUNT_BITS-1:0] cnt1_q, cnt2_q;
	logic [1:0]            zc_q;
	logic                  gate_q;
	logic [TIME_W-1:0]     off_time_q, window_end_q;
	logic [US_W-1:0]       shift_time_q;

	logic [DUTY_W-1:0]     ramp_duty_d;
	logic [COUNT_BITS-1:0] cnt1_d, cnt2_d;
	logic [1:0]            zc_d;
	logic                  gate_d;
	logic [TIME_W-1:0]     off_time_d, window_end_d;
	logic [US_W-1:0]       shift_time_d;

	// Reciprocal-scaled duty table: entry d holds d * ceil(2^30 / 100)
	logic [RECIP_W-1:0] recip_tbl [TBL_N];
	for (genvar i = 0; i < TBL_N; i++) begin : g_recip
		assign recip_tbl[i] = RECIP_W'(i * RECIP_M);
	end

	// Ramp step datapath
	logic [DUTY_W-1:0] tgt_sat, ramp_new;
	logic [PROD_W-1:0] prod;
	logic [US_W-1:0]   on_time, shift_new;
	logic              line_ok;

	assign line_ok = cfg.half_period_us != '0;
	assign tgt_sat = (target_duty > DUTY_FULL) ? DUTY_FULL : target_duty;

	always_comb begin
		ramp_new = ramp_duty_q;
		if (enable && line_ok) begin
			if (ramp_duty_q < tgt_sat)
				ramp_new = ramp_duty_q + 1'b1;
			else if (ramp_duty_q > tgt_sat)
				ramp_new = ramp_duty_q - 1'b1;
		end else if (ramp_duty_q != '0) begin
			ramp_new = ramp_duty_q - 1'b1;
		end
	end

	assign prod      = PROD_W'(cfg.half_period_us) * PROD_W'(recip_tbl[ramp_new]);
	assign on_time   = prod[RECIP_SHIFT +: US_W];
	assign shift_new = (cfg.half_period_us > cfg.zc_delay_adjust_us) ?
		cfg.half_period_us - cfg.zc_delay_adjust_us : '0;

	// Tick datapath
	logic [CW-1:0]     c1_base, c1_sum, c2_sum, edge_x, off_x, off_end_x, win_x;
	logic [COUNT_BITS-1:0] c1_base_n, c1_adv, c2_adv, c2_new;
	logic [TIME_W-1:0] edge_t;

	assign c1_base_n = (zc_q == ZC_PENDING) ? '0 : cnt1_q;
	assign c1_base   = CW'(c1_base_n);
	assign c1_sum    = c1_base + CW'(cfg.tick_step_us);
	assign c2_sum    = CW'(cnt2_q) + CW'(cfg.tick_step_us);
	assign c1_adv    = c1_sum[COUNT_BITS] ? CNT_MAX : c1_sum[COUNT_BITS-1:0];
	assign c2_adv    = c2_sum[COUNT_BITS] ? CNT_MAX : c2_sum[COUNT_BITS-1:0];
	assign edge_t    = TIME_W'(shift_time_q) + TIME_W'(cfg.zc_delay_adjust_us);
	assign edge_x    = CW'(edge_t);
	assign c2_new    = (CW'(c1_adv) > edge_x) ?
		COUNT_BITS'(CW'(c1_adv) - edge_x) : c2_adv;
	assign off_x     = CW'(off_time_q);
	assign off_end_x = off_x + CW'(cfg.pulse_width_us);
	assign win_x     = CW'(window_end_q);

	// Next state per command
	always_comb begin
		ramp_duty_d  = ramp_duty_q;
		cnt1_d       = cnt1_q;
		cnt2_d       = cnt2_q;
		zc_d         = zc_q;
		gate_d       = gate_q;
		off_time_d   = off_time_q;
		window_end_d = window_end_q;
		shift_time_d = shift_time_q;
		case (cmd)
			CMD_TICK: begin
				if (!enable && ramp_duty_q == '0) begin
					cnt1_d = '0;
					cnt2_d = '0;
				end else begin
					if (zc_q == ZC_PENDING) begin
						zc_d   = ZC_SEEN;
						cnt1_d = '0;
					end
					if (zc_q == ZC_PENDING || zc_q == ZC_SEEN) begin
						if (ramp_duty_q <= cfg.duty_low_limit) begin
							gate_d = 1'b0;
						end else if (ramp_duty_q >= cfg.duty_high_limit) begin
							gate_d = 1'b1;
						end else begin
							cnt1_d = c1_adv;
							cnt2_d = c2_new;
							// second-half counter overrides the first when both in window
							if (CW'(c1_adv) > off_x && CW'(c1_adv) < win_x)
								gate_d = !(CW'(c1_adv) > off_end_x);
							if (CW'(c2_new) > off_x && CW'(c2_new) < win_x)
								gate_d = !(CW'(c2_new) > off_end_x);
						end
					end
				end
			end
			CMD_ZC: begin
				zc_d = ZC_PENDING;
			end
			CMD_RAMP: begin
				ramp_duty_d = ramp_new;
				if (line_ok && ramp_new != '0) begin
					shift_time_d = shift_new;
					window_end_d = TIME_W'(cfg.half_period_us) + TIME_W'(shift_new);
					off_time_d   = TIME_W'(cfg.half_period_us - on_time) +
						TIME_W'(shift_new);
				end
			end
			default: ;
		endcase
	end

	// Commit state on each processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_duty_q  <= '0;
			cnt1_q       <= '0;
			cnt2_q       <= '0;
			zc_q         <= ZC_NONE;
			gate_q       <= 1'b0;
			off_time_q   <= '0;
			window_end_q <= '0;
			shift_time_q <= '0;
		end else if (step) begin
			ramp_duty_q  <= ramp_duty_d;
			cnt1_q       <= cnt1_d;
			cnt2_q       <= cnt2_d;
			zc_q         <= zc_d;
			gate_q       <= gate_d;
			off_time_q   <= off_time_d;
			window_end_q <= window_end_d;
			shift_time_q <= shift_time_d;
		end
	end

	assign gate_nxt = gate_d;
	assign duty_nxt = ramp_duty_d;

endmodule
